FILE: rtl/lkv_pkg.sv
// shared constants for the lru key/value cache
// no dependencies; used by the interfaces, the register block and the engine
package lkv_pkg;

  // payload widths
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CAP_W  = 5;

  // default number of entries
  localparam int unsigned ENTRIES_DEFAULT = 16;

  // register file layout
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic        REG_CAPACITY = 1'b0;
  localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

  // command codes
  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  // value returned by a get that misses
  localparam logic [DATA_W-1:0] MISS_VALUE = {DATA_W{1'b1}};

endpackage

FILE: rtl/lkv_if.sv
// request and response channel interfaces of the lru key/value cache
// depends on lkv_pkg for the payload widths
interface lkv_req_if;
  logic                               valid;
  logic                               ready;
  logic                               cmd;
  logic signed [lkv_pkg::DATA_W-1:0]  lookup_key;
  logic signed [lkv_pkg::DATA_W-1:0]  store_value;

  modport source (output valid, output cmd, output lookup_key, output store_value,
                  input ready);
  modport sink   (input valid, input cmd, input lookup_key, input store_value,
                  output ready);
endinterface

interface lkv_rsp_if;
  logic                               valid;
  logic                               ready;
  logic                               hit;
  logic signed [lkv_pkg::DATA_W-1:0]  read_value;
  logic                               evicted;

  modport source (output valid, output hit, output read_value, output evicted,
                  input ready);
  modport sink   (input valid, input hit, input read_value, input evicted,
                  output ready);
endinterface

FILE: rtl/lkv_cfg.sv
// apb register block: holds the capacity register and derives the effective capacity
// depends on lkv_pkg
module lkv_cfg #(
  parameter int unsigned ENTRIES = lkv_pkg::ENTRIES_DEFAULT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lkv_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [lkv_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [lkv_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  output logic [$clog2(ENTRIES+1)-1:0]    eff_cap_o
);

  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W = (CNT_W > lkv_pkg::CAP_W) ? CNT_W : lkv_pkg::CAP_W;

  logic [lkv_pkg::CAP_W-1:0] cap_q;
  logic                      sel_cap;
  logic                      wr_en;

  // word decode, byte offset ignored
  assign sel_cap = (paddr[lkv_pkg::APB_ADDR_W-1:2] == lkv_pkg::REG_CAPACITY);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lkv_pkg::CAPACITY_RESET;
    end else if (wr_en && sel_cap) begin
      cap_q <= pwdata[lkv_pkg::CAP_W-1:0];
    end
  end

  // readback
  assign prdata = sel_cap ? lkv_pkg::APB_DATA_W'(cap_q) : '0;

  // zero acts as one, anything above the entry count saturates
  always_comb begin
    if (cap_q == '0) begin
      eff_cap_o = CNT_W'(1);
    end else if (CMP_W'(cap_q) > CMP_W'(ENTRIES)) begin
      eff_cap_o = CNT_W'(ENTRIES);
    end else begin
      eff_cap_o = CNT_W'(cap_q);
    end
  end

endmodule

FILE: rtl/lkv_engine.sv
// lookup and recency engine: entry memory, sequencer and result register
// depends on lkv_pkg and the channel interfaces in lkv_if.sv
module lkv_engine #(
  parameter int unsigned ENTRIES = lkv_pkg::ENTRIES_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [$clog2(ENTRIES+1)-1:0]  eff_cap_i,
  lkv_req_if.sink                       req,
  lkv_rsp_if.source                     rsp
);

  localparam int unsigned DW     = lkv_pkg::DATA_W;
  localparam int unsigned IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned RANK_W = IDX_W;
  localparam int unsigned CNT_W  = $clog2(ENTRIES + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_UPDATE,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic [DW-1:0]     key;
    logic [DW-1:0]     value;
    logic [RANK_W-1:0] rank;
  } entry_t;

  // entry memory and its read register
  entry_t               mem_q [ENTRIES];
  entry_t               rdata_q;
  logic                 mem_re;
  logic [IDX_W-1:0]     mem_raddr;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  entry_t               mem_wdata;

  // control state
  state_e               state_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 rvalid_q;
  logic [IDX_W-1:0]     ridx_q;
  logic [ENTRIES-1:0]   valid_q;
  logic [ENTRIES-1:0]   valid_d;
  logic [CNT_W-1:0]     used_q;
  logic                 out_valid_q;
  logic                 out_load;

  // scan results
  logic                 found_q;
  logic [IDX_W-1:0]     slot_q;
  logic [RANK_W-1:0]    bound_q;
  logic                 age_all_q;
  logic [DW-1:0]        hitval_q;
  logic                 lru_have_q;
  logic [IDX_W-1:0]     lru_slot_q;
  logic [RANK_W-1:0]    lru_rank_q;
  logic                 free_have_q;
  logic [IDX_W-1:0]     free_slot_q;

  // captured transaction and results
  logic                 cmd_q;
  logic [DW-1:0]        key_q;
  logic [DW-1:0]        sval_q;
  logic [DW-1:0]        wval_q;
  logic                 res_hit_q;
  logic [DW-1:0]        res_val_q;
  logic                 res_ev_q;
  logic                 out_hit_q;
  logic [DW-1:0]        out_val_q;
  logic                 out_ev_q;

  logic                 accept;
  logic                 issue;
  logic                 last;
  logic                 rd_valid;
  logic                 rd_match;
  logic                 evict;
  logic                 insert;
  logic [IDX_W-1:0]     ins_slot;
  logic                 upd_self;
  logic                 upd_age;
  logic                 out_free;

  assign req.ready = (state_q == S_IDLE);
  assign accept    = req.valid && req.ready;

  // one memory read per cycle during both passes
  assign issue     = ((state_q == S_SCAN) || (state_q == S_UPDATE)) &&
                     (cnt_q < CNT_W'(ENTRIES));
  assign mem_re    = issue;
  assign mem_raddr = cnt_q[IDX_W-1:0];
  assign last      = rvalid_q && (ridx_q == IDX_W'(ENTRIES - 1));

  assign rd_valid  = valid_q[ridx_q];
  assign rd_match  = rd_valid && (rdata_q.key == key_q);

  // miss handling for a put
  assign evict    = !found_q && (cmd_q == lkv_pkg::CMD_PUT) && lru_have_q &&
                    (used_q != '0) && (used_q >= eff_cap_i);
  assign ins_slot = (evict && !(free_have_q && (free_slot_q < lru_slot_q))) ?
                    lru_slot_q : free_slot_q;
  assign insert   = !found_q && (cmd_q == lkv_pkg::CMD_PUT) && (free_have_q || evict);

  // valid bits after the decision: evicted slot cleared, inserted slot set
  always_comb begin
    valid_d = valid_q;
    if (state_q == S_DECIDE) begin
      if (evict) begin
        valid_d[lru_slot_q] = 1'b0;
      end
      if (insert) begin
        valid_d[ins_slot] = 1'b1;
      end
    end
  end

  // recency rewrite during the update pass
  assign upd_self  = (ridx_q == slot_q);
  assign upd_age   = rd_valid && (age_all_q || (rdata_q.rank < bound_q));
  assign mem_we    = (state_q == S_UPDATE) && rvalid_q && (upd_self || upd_age);
  assign mem_waddr = ridx_q;
  always_comb begin
    if (upd_self) begin
      mem_wdata = '{key: key_q, value: wval_q, rank: '0};
    end else begin
      mem_wdata = '{key: rdata_q.key, value: rdata_q.value,
                    rank: rdata_q.rank + RANK_W'(1)};
    end
  end

  assign out_free = !out_valid_q || rsp.ready;
  assign out_load = (state_q == S_FINISH) && out_free;

  // entry memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  // sequencer, valid bits, fill count and output handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      rvalid_q    <= 1'b0;
      ridx_q      <= '0;
      valid_q     <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      lru_have_q  <= 1'b0;
      free_have_q <= 1'b0;
    end else begin
      rvalid_q <= issue;
      ridx_q   <= cnt_q[IDX_W-1:0];
      valid_q  <= valid_d;
      if (issue) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && rsp.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q     <= S_SCAN;
            cnt_q       <= '0;
            found_q     <= 1'b0;
            lru_have_q  <= 1'b0;
            free_have_q <= 1'b0;
          end
        end
        S_SCAN: begin
          if (rvalid_q) begin
            if (rd_match && !found_q) begin
              found_q <= 1'b1;
            end
            if (rd_valid && (!lru_have_q || (rdata_q.rank > lru_rank_q))) begin
              lru_have_q <= 1'b1;
            end
            if (!rd_valid && !free_have_q) begin
              free_have_q <= 1'b1;
            end
          end
          if (last) begin
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          cnt_q <= '0;
          if (found_q || insert) begin
            state_q <= S_UPDATE;
          end else begin
            state_q <= S_FINISH;
          end
          used_q <= used_q - CNT_W'(evict) + CNT_W'(insert);
        end
        S_UPDATE: begin
          if (last) begin
            state_q <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= req.cmd;
      key_q  <= req.lookup_key;
      sval_q <= req.store_value;
    end
    // lookup pass bookkeeping
    if ((state_q == S_SCAN) && rvalid_q) begin
      if (rd_match && !found_q) begin
        slot_q   <= ridx_q;
        bound_q  <= rdata_q.rank;
        hitval_q <= rdata_q.value;
      end
      if (rd_valid && (!lru_have_q || (rdata_q.rank > lru_rank_q))) begin
        lru_slot_q <= ridx_q;
        lru_rank_q <= rdata_q.rank;
      end
      if (!rd_valid && !free_have_q) begin
        free_slot_q <= ridx_q;
      end
    end
    // result and update-pass setup
    if (state_q == S_DECIDE) begin
      res_hit_q <= found_q;
      res_ev_q  <= evict;
      if (cmd_q == lkv_pkg::CMD_PUT) begin
        res_val_q <= '0;
      end else if (found_q) begin
        res_val_q <= hitval_q;
      end else begin
        res_val_q <= lkv_pkg::MISS_VALUE;
      end
      if (found_q) begin
        age_all_q <= 1'b0;
        wval_q    <= (cmd_q == lkv_pkg::CMD_PUT) ? sval_q : hitval_q;
      end else begin
        age_all_q <= 1'b1;
        slot_q    <= ins_slot;
        wval_q    <= sval_q;
      end
    end
    // output register
    if (out_load) begin
      out_hit_q <= res_hit_q;
      out_val_q <= res_val_q;
      out_ev_q  <= res_ev_q;
    end
  end

  assign rsp.valid      = out_valid_q;
  assign rsp.hit        = out_hit_q;
  assign rsp.read_value = out_val_q;
  assign rsp.evicted    = out_ev_q;

  // fill count tracks the valid bits
  a_used_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == used_q)
    else $error("fill count differs from number of valid entries");

  // never more entries in use than slots
  a_used_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CNT_W'(ENTRIES))
    else $error("fill count above entry count");

  // an eviction only happens on a put that missed
  a_evict_not_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_ev_q |-> !out_hit_q)
    else $error("eviction reported together with a hit");

  // the lookup pass is fully drained before the decision
  a_scan_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DECIDE) |-> (!rvalid_q && (cnt_q == CNT_W'(ENTRIES))))
    else $error("decision taken with memory reads outstanding");

  // the memory is only written during the update pass
  a_write_in_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(state_q) == S_SCAN && state_q == S_SCAN |-> !mem_we)
    else $error("memory write during lookup pass");

endmodule

FILE: rtl/lru_key_value_cache.sv
// top level of the lru key/value cache
// depends on lkv_pkg, lkv_if.sv, lkv_cfg and lkv_engine
//
// Fully associative key/value store with least-recently-used replacement.
// Requests arrive on req_i (valid/ready, cmd 0 = get, 1 = put, lookup_key,
// store_value); each transaction yields exactly one response on rsp_o (hit,
// read_value, evicted). A get hit returns the value, a get miss returns -1,
// a put returns 0. The capacity register (APB, byte address 0) limits the
// entries in use before a missing put evicts the least recent entry.
// Each request runs passes over the entry memory (one read and one write
// port), one entry per cycle: a lookup pass that finds the key, the oldest
// entry and the first free slot and, unless the request is a get that
// misses, an update pass that rewrites the recency ranks. Only one request
// is in flight at a time.
// The response sits in an output register; a new request is accepted while
// it waits, and a stalled receiver holds the block only when the next
// response is ready to be loaded.
// Reset empties the store (all entries invalid, count zero) and sets the
// capacity to 16; no clearing pass is needed.
module lru_key_value_cache #(
  parameter int unsigned ENTRIES = lkv_pkg::ENTRIES_DEFAULT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  lkv_req_if.sink                         req_i,
  lkv_rsp_if.source                       rsp_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lkv_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [lkv_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [lkv_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);

  logic [$clog2(ENTRIES+1)-1:0] eff_cap;

  // configuration registers
  lkv_cfg #(
    .ENTRIES (ENTRIES)
  ) u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .eff_cap_o (eff_cap)
  );

  // lookup and replacement engine
  lkv_engine #(
    .ENTRIES (ENTRIES)
  ) u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .eff_cap_i (eff_cap),
    .req       (req_i),
    .rsp       (rsp_o)
  );

endmodule
